/* rtl/ttw_pkg.sv */
// ----------------------------------------------------------------------------
// ttw_pkg
// Shared constants, types and field widths for the tile text word wrap core.
// ----------------------------------------------------------------------------
`default_nettype none

package ttw_pkg;

	localparam int MAX_WORD   = 32;
	localparam int COORD_BITS = 16;

	localparam int WL_W   = $clog2(MAX_WORD + 1);
	localparam int ADDR_W = $clog2(MAX_WORD);

	localparam int CHAR_W = 8;
	localparam int TILE_W = 8;
	localparam int WRAP_W = 16;
	localparam int DATA_W = 16;
	localparam int POS_W  = WRAP_W + 1;
	localparam int PROD_W = TILE_W + WL_W;
	localparam int NIB_W  = 4;

	localparam int IN_TDATA_W  = 8 * ((CHAR_W + 2 * COORD_BITS + 7) / 8);
	localparam int OUT_FIELD_W = 2 * NIB_W + 4 * COORD_BITS + 1;
	localparam int OUT_TDATA_W = 8 * ((OUT_FIELD_W + 7) / 8);
	localparam int IN_TUSER_W  = 2;

	localparam logic [CHAR_W-1:0] TERM_CODE  = 8'd0;
	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;

	localparam logic [TILE_W-1:0] TILE_W_RST = 8'd8;
	localparam logic [TILE_W-1:0] TILE_H_RST = 8'd8;
	localparam logic [WRAP_W-1:0] WRAP_RST   = 16'd640;
	localparam logic [WRAP_W-1:0] COLS_RST   = WRAP_RST / WRAP_W'(TILE_W_RST);

	typedef enum logic [1:0] {
		CFG_TILE_WIDTH  = 2'd0,
		CFG_TILE_HEIGHT = 2'd1,
		CFG_WRAP_WIDTH  = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

	localparam logic RES_GLYPH  = 1'b0;
	localparam logic RES_REPORT = 1'b1;

	typedef struct packed {
		logic              start;
		logic [WRAP_W-1:0] dividend;
		logic [TILE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WRAP_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

/* rtl/ttw_ram.sv */
// ----------------------------------------------------------------------------
// ttw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/ttw_div.sv */
// ----------------------------------------------------------------------------
// ttw_div
// Restoring divider, one quotient bit per cycle: columns = wrap / tile width.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ttw_pkg::div_req_t req,
	output ttw_pkg::div_rsp_t      rsp
);

	import ttw_pkg::*;

	localparam int CNT_W = $clog2(WRAP_W);

	logic [WRAP_W-1:0] dividend_q;
	logic [WRAP_W-1:0] quot_q;
	logic [TILE_W-1:0] divisor_q;
	logic [TILE_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [TILE_W:0]   shifted;
	logic              ge;
	logic [TILE_W-1:0] diff;

	always_comb begin
		shifted = {rem_q, dividend_q[WRAP_W-1]};
		ge      = shifted >= {1'b0, divisor_q};
		diff    = shifted[TILE_W-1:0] - divisor_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(WRAP_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WRAP_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= req.dividend;
			divisor_q  <= req.divisor;
			rem_q      <= '0;
			quot_q     <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[WRAP_W-2:0], 1'b0};
			rem_q      <= ge ? diff : shifted[TILE_W-1:0];
			quot_q     <= {quot_q[WRAP_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = (divisor_q == '0) ? '0 : quot_q;

endmodule

`default_nettype wire

/* rtl/tile_text_word_wrap_core.sv */
// ----------------------------------------------------------------------------
// tile_text_word_wrap_core
// Greedy word wrap of a byte stream onto fixed-size glyph tiles.
// ----------------------------------------------------------------------------
// An ordinary byte is taken while idle and gives no result. A space or terminator
// closing a word passes through PLACE1 and PLACE2, then per glyph a buffer read and
// an output load (none when measuring), then the report after a terminator.
// A busy receiver stretches each output load until the register frees up.
// A write of tile width or wrap width runs the divider to update the column limit.
// Reset (arst_n, async, low) clears the layout; the word buffer is not cleared.
`default_nettype none

module tile_text_word_wrap_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// char_code[7:0], start_x[23:8], start_y[39:24]
	input  wire logic [ttw_pkg::IN_TDATA_W-1:0]     s_tdata,
	// first_of_text[0], measure_only[1]
	input  wire logic [ttw_pkg::IN_TUSER_W-1:0]     s_tuser,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// tile_column[3:0], tile_row[7:4], dest_x[23:8], dest_y[39:24],
	// text_width[55:40], text_height[71:56], word_overflow[72], zero fill above
	output logic      [ttw_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// result_kind[0]
	output logic                                    m_tuser,
	output logic                                    m_tlast,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [1:0]                         cfg_index,
	input  wire logic [ttw_pkg::DATA_W-1:0]         cfg_data
);

	import ttw_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_DIV     = 7'b0000010,
		ST_PLACE1  = 7'b0000100,
		ST_PLACE2  = 7'b0001000,
		ST_EMIT_RD = 7'b0010000,
		ST_EMIT_WR = 7'b0100000,
		ST_REPORT  = 7'b1000000
	} state_t;

	state_t st_q;

	logic [TILE_W-1:0]     tw_q;
	logic [TILE_W-1:0]     th_q;
	logic [WRAP_W-1:0]     wrap_q;
	logic [WRAP_W-1:0]     cols_q;
	logic [WL_W-1:0]       wl_q;
	logic [POS_W-1:0]      lp_q;
	logic [COORD_BITS-1:0] pen_x_q;
	logic [COORD_BITS-1:0] pen_y_q;
	logic [COORD_BITS-1:0] origin_q;
	logic [COORD_BITS-1:0] max_ext_q;
	logic                  first_q;
	logic                  after_sp_q;
	logic                  ovf_q;
	logic                  meas_q;
	logic                  term_q;

	logic [WL_W-1:0]       n_q;
	logic [WL_W-1:0]       j_q;
	logic                  over_q;
	logic [PROD_W-1:0]     prod_q;
	logic [PROD_W:0]       adv_q;
	logic [COORD_BITS-1:0] rel_q;
	logic [COORD_BITS-1:0] emit_x_q;
	logic [COORD_BITS-1:0] emit_y_q;

	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic                   m_kind_q;
	logic                   m_last_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [CHAR_W-1:0]     in_char;
	logic [COORD_BITS-1:0] in_sx;
	logic [COORD_BITS-1:0] in_sy;
	logic                  in_first;
	logic                  in_meas;
	logic                  in_xfer;
	logic                  cfg_xfer;
	logic [WL_W-1:0]       wl_eff;
	logic                  as_eff;
	logic                  buf_we;
	logic [CHAR_W-1:0]     buf_rd;
	logic                  buf_re;
	logic                  out_free;
	logic                  out_load;

	logic [POS_W:0]        fit_sum;
	logic [PROD_W-1:0]     prod_c;
	logic                  case_new;
	logic [COORD_BITS-1:0] ext_a;
	logic [COORD_BITS-1:0] ext_b;
	logic [COORD_BITS-1:0] ext;
	logic [COORD_BITS-1:0] adv_c;
	logic [COORD_BITS-1:0] pen_y_adv;
	logic [POS_W-1:0]      n_inc;

	always_comb begin
		in_char  = s_tdata[CHAR_W-1:0];
		in_sx    = s_tdata[CHAR_W +: COORD_BITS];
		in_sy    = s_tdata[CHAR_W + COORD_BITS +: COORD_BITS];
		in_first = s_tuser[0];
		in_meas  = s_tuser[1];

		s_tready  = (st_q == ST_IDLE) && !cfg_valid;
		cfg_ready = (st_q == ST_IDLE);
		in_xfer   = s_tvalid && s_tready;
		cfg_xfer  = cfg_valid && cfg_ready;
		out_free  = !m_valid_q || m_tready;
		out_load  = ((st_q == ST_EMIT_WR) || (st_q == ST_REPORT)) && out_free;

		wl_eff = in_first ? '0 : wl_q;
		as_eff = in_first ? 1'b0 : after_sp_q;
		buf_we = in_xfer && (in_char != TERM_CODE) && (in_char != SPACE_CODE) &&
			(wl_eff < WL_W'(MAX_WORD));
		buf_re = (st_q == ST_EMIT_RD);

		div_req.start    = cfg_xfer && ((cfg_index == CFG_TILE_WIDTH) ||
			(cfg_index == CFG_WRAP_WIDTH));
		div_req.dividend = (cfg_index == CFG_WRAP_WIDTH) ? cfg_data : wrap_q;
		div_req.divisor  = (cfg_index == CFG_TILE_WIDTH) ? cfg_data[TILE_W-1:0] : tw_q;

		fit_sum = {1'b0, lp_q} + (POS_W + 1)'(wl_q);
		prod_c  = PROD_W'(tw_q) * PROD_W'(wl_q);

		case_new  = over_q && !first_q;
		adv_c     = COORD_BITS'(adv_q);
		pen_y_adv = pen_y_q + COORD_BITS'(th_q);
		n_inc     = POS_W'(n_q) + 1'b1;
		ext_a     = case_new ? '0 : rel_q;
		ext_b     = (over_q && first_q) ? COORD_BITS'(prod_q) : adv_c;
		ext       = ext_a + ext_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			tw_q       <= TILE_W_RST;
			th_q       <= TILE_H_RST;
			wrap_q     <= WRAP_RST;
			cols_q     <= COLS_RST;
			wl_q       <= '0;
			lp_q       <= '0;
			pen_x_q    <= '0;
			pen_y_q    <= '0;
			origin_q   <= '0;
			max_ext_q  <= '0;
			first_q    <= 1'b1;
			after_sp_q <= 1'b0;
			ovf_q      <= 1'b0;
			meas_q     <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (cfg_xfer) begin
						case (cfg_index)
							CFG_TILE_WIDTH:  tw_q   <= cfg_data[TILE_W-1:0];
							CFG_TILE_HEIGHT: th_q   <= cfg_data[TILE_W-1:0];
							CFG_WRAP_WIDTH:  wrap_q <= cfg_data;
							default: ;
						endcase
						if (div_req.start) begin
							st_q <= ST_DIV;
						end
					end else if (in_xfer) begin
						if (in_first) begin
							origin_q  <= in_sx;
							pen_x_q   <= in_sx;
							pen_y_q   <= in_sy;
							lp_q      <= '0;
							max_ext_q <= '0;
							first_q   <= 1'b1;
							ovf_q     <= 1'b0;
							meas_q    <= in_meas;
						end
						if (in_char == TERM_CODE) begin
							wl_q       <= wl_eff;
							after_sp_q <= 1'b0;
							st_q       <= as_eff ? ST_REPORT : ST_PLACE1;
						end else if (in_char == SPACE_CODE) begin
							wl_q       <= wl_eff;
							after_sp_q <= 1'b1;
							st_q       <= ST_PLACE1;
						end else begin
							after_sp_q <= 1'b0;
							if (buf_we) begin
								wl_q <= wl_eff + 1'b1;
							end else begin
								wl_q  <= wl_eff;
								ovf_q <= 1'b1;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						cols_q <= div_rsp.quot;
						st_q   <= ST_IDLE;
					end
				end
				ST_PLACE1: begin
					st_q <= ST_PLACE2;
				end
				ST_PLACE2: begin
					wl_q <= '0;
					if ($signed(ext) > $signed(max_ext_q)) begin
						max_ext_q <= ext;
					end
					if (!over_q) begin
						lp_q    <= lp_q + n_inc;
						pen_x_q <= pen_x_q + adv_c;
						first_q <= 1'b0;
					end else if (first_q) begin
						lp_q    <= '0;
						pen_x_q <= origin_q;
						pen_y_q <= pen_y_adv;
					end else begin
						lp_q    <= n_inc;
						pen_x_q <= origin_q + adv_c;
						pen_y_q <= pen_y_adv;
					end
					if (meas_q || (n_q == '0)) begin
						st_q <= term_q ? ST_REPORT : ST_IDLE;
					end else begin
						st_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					st_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						if (j_q == n_q - 1'b1) begin
							st_q <= term_q ? ST_REPORT : ST_IDLE;
						end else begin
							st_q <= ST_EMIT_RD;
						end
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			term_q <= (in_char == TERM_CODE);
		end
		if (st_q == ST_PLACE1) begin
			n_q    <= wl_q;
			over_q <= fit_sum > (POS_W + 1)'(cols_q);
			prod_q <= prod_c;
			adv_q  <= {1'b0, prod_c} + (PROD_W + 1)'(tw_q);
			rel_q  <= pen_x_q - origin_q;
		end
		if (st_q == ST_PLACE2) begin
			j_q      <= '0;
			emit_x_q <= case_new ? origin_q : pen_x_q;
			emit_y_q <= case_new ? pen_y_adv : pen_y_q;
		end
		if ((st_q == ST_EMIT_WR) && out_free) begin
			j_q      <= j_q + 1'b1;
			emit_x_q <= emit_x_q + COORD_BITS'(tw_q);
			m_kind_q <= RES_GLYPH;
			m_last_q <= (j_q == n_q - 1'b1) && !term_q;
			m_data_q <= OUT_TDATA_W'({emit_y_q, emit_x_q, buf_rd[CHAR_W-1:NIB_W],
				buf_rd[NIB_W-1:0]});
		end
		if ((st_q == ST_REPORT) && out_free) begin
			m_kind_q <= RES_REPORT;
			m_last_q <= 1'b1;
			m_data_q <= OUT_TDATA_W'({ovf_q, pen_y_adv, max_ext_q,
				{(2*NIB_W + 2*COORD_BITS){1'b0}}});
		end
	end

	ttw_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_WORD)
	) u_word_buf (
		.clk    (clk),
		.wr_en  (buf_we),
		.wr_addr(wl_eff[ADDR_W-1:0]),
		.wr_data(in_char),
		.rd_en  (buf_re),
		.rd_addr(j_q[ADDR_W-1:0]),
		.rd_data(buf_rd)
	);

	ttw_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

	a_report_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == RES_REPORT)) |-> m_tlast)
		else $error("size report without last marker");

	a_read_in_word: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT_RD) |-> ((j_q < n_q) && (n_q <= WL_W'(MAX_WORD))))
		else $error("glyph read beyond buffered word");

	a_word_len: assert property (@(posedge clk) disable iff (!arst_n)
		wl_q <= WL_W'(MAX_WORD))
		else $error("word length beyond buffer");

	a_cols_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> (cols_q <= wrap_q))
		else $error("column limit above wrap width");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (st_q == ST_DIV))
		else $error("divider busy outside config update");

endmodule

`default_nettype wire
